>>> sv/nchs_pkg.sv
package nchs_pkg;

   localparam int CELL_BITS = 16;
   localparam int NODE_BITS = 32;
   localparam int RNTI_BITS = 16;
   localparam int SLOT_BITS = 6;
   localparam int CSR_BITS  = 7;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

>>> sv/nchs_req_if.sv
interface nchs_req_if #(
   parameter int COORD_BITS = 24
);
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [nchs_pkg::SLOT_BITS-1:0]  slot;
   logic [nchs_pkg::CELL_BITS-1:0]  cell_id;
   logic [nchs_pkg::NODE_BITS-1:0]  node_id;
   logic [nchs_pkg::RNTI_BITS-1:0]  rnti;
   logic signed [COORD_BITS-1:0]    pos_x;
   logic signed [COORD_BITS-1:0]    pos_y;
   logic signed [COORD_BITS-1:0]    pos_z;

   modport source (
      output valid, command, slot, cell_id, node_id, rnti, pos_x, pos_y, pos_z,
      input  ready
   );
   modport sink (
      input  valid, command, slot, cell_id, node_id, rnti, pos_x, pos_y, pos_z,
      output ready
   );
endinterface

>>> sv/nchs_rsp_if.sv
interface nchs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nchs_pkg::NODE_BITS-1:0]  target_node_id;
   logic [nchs_pkg::RNTI_BITS-1:0]  target_rnti;
   logic [nchs_pkg::CELL_BITS-1:0]  new_cell_id;
   logic                            serving_found;

   modport source (
      output valid, target_node_id, target_rnti, new_cell_id, serving_found,
      input  ready
   );
   modport sink (
      input  valid, target_node_id, target_rnti, new_cell_id, serving_found,
      output ready
   );
endinterface

>>> sv/nearest_cell_handover_select_core.sv
// Load transaction: written into the station memory at acceptance.
// Query transaction: scans n stored entries (stays idle, no result, when n is 0);
// one shared squarer handles x, y, z of an entry in turn, one adder sums them.
// Input is not ready while a query scans or hands off; a result sits in an output
// register, so the next transaction is accepted while it waits to be taken.
// Synchronous active-high reset clears control state and the scan length; the
// station memory is not cleared and holds garbage until loaded.
module nearest_cell_handover_select_core #(
   parameter int MAX_STATIONS = 64,
   parameter int COORD_BITS   = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   nchs_req_if.sink                       req_chan,
   nchs_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [nchs_pkg::CSR_BITS-1:0]  csr_wr_data
);

   localparam int IDX_BITS   = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_STATIONS + 1);
   localparam int CELL_BITS  = nchs_pkg::CELL_BITS;
   localparam int NODE_BITS  = nchs_pkg::NODE_BITS;
   localparam int RNTI_BITS  = nchs_pkg::RNTI_BITS;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 2;
   localparam int ENTRY_BITS = CELL_BITS + NODE_BITS + 3 * COORD_BITS;
   // field offsets inside a memory word: {cell, node, x, y, z}
   localparam int Z_LSB      = 0;
   localparam int Y_LSB      = COORD_BITS;
   localparam int X_LSB      = 2 * COORD_BITS;
   localparam int NODE_LSB   = 3 * COORD_BITS;
   localparam int CELL_LSB   = NODE_LSB + NODE_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SUM, S_CMP, S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [nchs_pkg::CSR_BITS-1:0] entries_ff;
   logic [CNT_BITS-1:0]      n_ff, n_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [CELL_BITS-1:0]     q_cell_ff;
   logic [RNTI_BITS-1:0]     q_rnti_ff;
   logic [COORD_BITS-1:0]    q_x_ff, q_y_ff, q_z_ff;
   logic [ENTRY_BITS-1:0]    mem [MAX_STATIONS];
   logic [ENTRY_BITS-1:0]    entry_ff;
   logic [SQ_BITS-1:0]       sq_ff;
   logic [DIST_BITS-1:0]     acc_ff, best_ff;
   logic [CELL_BITS-1:0]     nearest_ff;
   logic [NODE_BITS-1:0]     serving_node_ff;
   logic                     found_ff;
   logic                     rsp_valid_ff;
   logic [NODE_BITS-1:0]     rsp_node_ff;
   logic [RNTI_BITS-1:0]     rsp_rnti_ff;
   logic [CELL_BITS-1:0]     rsp_cell_ff;
   logic                     rsp_found_ff;

   logic                     req_take;
   logic                     load_wr;
   logic [CNT_BITS-1:0]      cfg_n;
   logic [COORD_BITS-1:0]    sq_q, sq_e;
   logic signed [COORD_BITS:0] diff;
   logic [COORD_BITS-1:0]    mag;
   logic [SQ_BITS-1:0]       sq_res;
   logic [DIST_BITS-1:0]     acc_sum;
   logic [CELL_BITS-1:0]     e_cell;
   logic [NODE_BITS-1:0]     e_node;
   logic                     rsp_free;
   logic                     rsp_load;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign load_wr        = req_take && (req_chan.command == nchs_pkg::CMD_LOAD) &&
                           (32'(req_chan.slot) < 32'(MAX_STATIONS));

   // scan length saturates at the table depth
   assign cfg_n = (32'(entries_ff) > 32'(MAX_STATIONS)) ? CNT_BITS'(MAX_STATIONS)
                                                       : CNT_BITS'(entries_ff);

   assign e_cell = entry_ff[CELL_LSB +: CELL_BITS];
   assign e_node = entry_ff[NODE_LSB +: NODE_BITS];

   // shared squarer: one coordinate per cycle
   always_comb begin
      case (state_ff)
         S_SQ_X: begin
            sq_q = q_x_ff;
            sq_e = entry_ff[X_LSB +: COORD_BITS];
         end
         S_SQ_Y: begin
            sq_q = q_y_ff;
            sq_e = entry_ff[Y_LSB +: COORD_BITS];
         end
         default: begin
            sq_q = q_z_ff;
            sq_e = entry_ff[Z_LSB +: COORD_BITS];
         end
      endcase
      diff   = $signed({sq_q[COORD_BITS-1], sq_q}) - $signed({sq_e[COORD_BITS-1], sq_e});
      mag    = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
      sq_res = SQ_BITS'(mag) * SQ_BITS'(mag);
   end

   // shared accumulator adder; starts from zero on the first term
   assign acc_sum = ((state_ff == S_SQ_Y) ? '0 : acc_ff) + DIST_BITS'(sq_ff);

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = (state_ff == S_DONE) && (nearest_ff != q_cell_ff) && rsp_free;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take && (req_chan.command == nchs_pkg::CMD_QUERY)) begin
               n_in     = cfg_n;
               cnt_in   = '0;
               state_in = (cfg_n == '0) ? S_IDLE : S_FETCH;
            end
         end
         S_FETCH: state_in = S_SQ_X;
         S_SQ_X:  state_in = S_SQ_Y;
         S_SQ_Y:  state_in = S_SQ_Z;
         S_SQ_Z:  state_in = S_SUM;
         S_SUM: begin
            // next entry address moves now; CMP still sees the current word
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_CMP;
         end
         S_CMP:   state_in = (cnt_ff == n_ff) ? S_DONE : S_SQ_X;
         S_DONE: begin
            if (nearest_ff == q_cell_ff || rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         mem[IDX_BITS'(req_chan.slot)] <= {req_chan.cell_id, req_chan.node_id,
                                           req_chan.pos_x, req_chan.pos_y, req_chan.pos_z};
      end
      entry_ff <= mem[cnt_ff[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= '0;
         n_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            entries_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  q_cell_ff       <= req_chan.cell_id;
                  q_rnti_ff       <= req_chan.rnti;
                  q_x_ff          <= req_chan.pos_x;
                  q_y_ff          <= req_chan.pos_y;
                  q_z_ff          <= req_chan.pos_z;
                  nearest_ff      <= req_chan.cell_id;
                  found_ff        <= 1'b0;
                  serving_node_ff <= '0;
               end
            end
            S_SQ_X: sq_ff <= sq_res;
            S_SQ_Y: begin
               acc_ff <= acc_sum;
               sq_ff  <= sq_res;
            end
            S_SQ_Z: begin
               acc_ff <= acc_sum;
               sq_ff  <= sq_res;
            end
            S_SUM:  acc_ff <= acc_sum;
            S_CMP: begin
               // first entry always takes the minimum; ties keep the earlier one
               if (cnt_ff == CNT_BITS'(1) || acc_ff < best_ff) begin
                  best_ff    <= acc_ff;
                  nearest_ff <= e_cell;
               end
               if (e_cell == q_cell_ff) begin
                  found_ff        <= 1'b1;
                  serving_node_ff <= e_node;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_node_ff  <= serving_node_ff;
                  rsp_rnti_ff  <= q_rnti_ff;
                  rsp_cell_ff  <= nearest_ff;
                  rsp_found_ff <= found_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.target_node_id = rsp_node_ff;
   assign rsp_chan.target_rnti    = rsp_rnti_ff;
   assign rsp_chan.new_cell_id    = rsp_cell_ff;
   assign rsp_chan.serving_found  = rsp_found_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside of scan completion");

   a_rsp_is_handover: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_cell_ff != $past(q_cell_ff))
      else $error("result issued although nearest cell is the serving cell");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> cnt_ff <= n_ff)
      else $error("scan ran past the configured entry count");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_node_ff == '0)
      else $error("serving node id nonzero without a serving match");

endmodule
